### src/plc_pkg.sv
// Shared types, codes and line classification functions for the POP3 line classifier.
`default_nettype none
package plc_pkg;

    // Maximum results one input can cause: three released prefix bytes and two payload bytes.
    localparam int MAX_RES = 5;

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_PLUS     = 3'd1,
        PH_PLUS_O   = 3'd2,
        PH_MINUS    = 3'd3,
        PH_MINUS_E  = 3'd4,
        PH_MINUS_ER = 3'd5,
        PH_BODY     = 3'd6
    } t_phase;

    localparam logic [1:0] KIND_CMD = 2'd0;
    localparam logic [1:0] KIND_POS = 2'd1;
    localparam logic [1:0] KIND_NEG = 2'd2;

    localparam logic [1:0] ROLE_NAME = 2'd0;
    localparam logic [1:0] ROLE_ARG  = 2'd1;
    localparam logic [1:0] ROLE_TEXT = 2'd2;
    localparam logic [1:0] ROLE_NONE = 2'd3;

    localparam logic [2:0] EV_BYTE    = 3'd0;
    localparam logic [2:0] EV_LINE    = 3'd1;
    localparam logic [2:0] EV_EMPTY   = 3'd2;
    localparam logic [2:0] EV_NO_CRLF = 3'd3;
    localparam logic [2:0] EV_NO_DATA = 3'd4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_R     = 8'h52;

    typedef struct packed {
        logic [2:0][7:0] held;
        logic [1:0]      held_cnt;
        t_phase          phase;
        logic [1:0]      kind;
        logic            space_seen;
        logic            drop_sp;
        logic            cr_pend;
        logic            has_bytes;
    } t_line;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] role;
        logic [1:0] kind;
        logic [2:0] ev;
    } t_res;

    typedef struct packed {
        t_res [MAX_RES-1:0] res;
        logic [2:0]         cnt;
    } t_bundle;

    typedef struct packed {
        t_line   st;
        t_bundle bun;
    } t_work;

    function automatic t_work f_emit(t_work w, logic [7:0] d, logic [1:0] role,
                                     logic [1:0] kind, logic [2:0] ev);
        if (w.bun.cnt < 3'(MAX_RES)) begin
            w.bun.res[w.bun.cnt] = '{data: d, role: role, kind: kind, ev: ev};
            w.bun.cnt = 3'(w.bun.cnt + 3'd1);
        end
        return w;
    endfunction

    function automatic t_line f_clear(t_line st);
        st.held_cnt   = 2'd0;
        st.phase      = PH_START;
        st.kind       = KIND_CMD;
        st.space_seen = 1'b0;
        st.drop_sp    = 1'b0;
        st.cr_pend    = 1'b0;
        st.has_bytes  = 1'b0;
        return st;
    endfunction

    function automatic t_work f_body(t_work w, logic [7:0] b);
        if (w.st.drop_sp) begin
            w.st.drop_sp = 1'b0;
            if (b == CH_SPACE) begin
                return w;
            end
        end
        if (w.st.kind != KIND_CMD) begin
            w = f_emit(w, b, ROLE_TEXT, w.st.kind, EV_BYTE);
        end else if (!w.st.space_seen) begin
            if (b == CH_SPACE) begin
                w.st.space_seen = 1'b1;
            end else begin
                w = f_emit(w, b, ROLE_NAME, KIND_CMD, EV_BYTE);
            end
        end else begin
            w = f_emit(w, b, ROLE_ARG, KIND_CMD, EV_BYTE);
        end
        return w;
    endfunction

    // Prefix did not match: held bytes go out as command name bytes.
    function automatic t_work f_release(t_work w);
        logic [1:0] n;
        n = w.st.held_cnt;
        w.st.phase    = PH_BODY;
        w.st.kind     = KIND_CMD;
        w.st.held_cnt = 2'd0;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < n) begin
                w = f_body(w, w.st.held[i]);
            end
        end
        return w;
    endfunction

    function automatic t_work f_hold(t_work w, logic [7:0] b, t_phase ph);
        if (w.st.held_cnt < 2'd3) begin
            w.st.held[w.st.held_cnt] = b;
        end
        w.st.held_cnt = 2'(w.st.held_cnt + 2'd1);
        w.st.phase    = ph;
        return w;
    endfunction

    function automatic t_work f_match(t_work w, logic [1:0] kind);
        w.st.held_cnt = 2'd0;
        w.st.phase    = PH_BODY;
        w.st.kind     = kind;
        w.st.drop_sp  = 1'b1;
        return w;
    endfunction

    function automatic t_work f_data(t_work w, logic [7:0] b);
        w.st.has_bytes = 1'b1;
        case (w.st.phase)
            PH_START: begin
                if (b == CH_PLUS) begin
                    return f_hold(w, b, PH_PLUS);
                end
                if (b == CH_MINUS) begin
                    return f_hold(w, b, PH_MINUS);
                end
                w.st.phase = PH_BODY;
                w.st.kind  = KIND_CMD;
            end
            PH_PLUS: begin
                if (b == CH_O) begin
                    return f_hold(w, b, PH_PLUS_O);
                end
                w = f_release(w);
            end
            PH_PLUS_O: begin
                if (b == CH_K) begin
                    return f_match(w, KIND_POS);
                end
                w = f_release(w);
            end
            PH_MINUS: begin
                if (b == CH_E) begin
                    return f_hold(w, b, PH_MINUS_E);
                end
                w = f_release(w);
            end
            PH_MINUS_E: begin
                if (b == CH_R) begin
                    return f_hold(w, b, PH_MINUS_ER);
                end
                w = f_release(w);
            end
            PH_MINUS_ER: begin
                if (b == CH_R) begin
                    return f_match(w, KIND_NEG);
                end
                w = f_release(w);
            end
            default: begin
            end
        endcase
        return f_body(w, b);
    endfunction

    function automatic t_work f_step(t_line st, logic [7:0] b, logic eod);
        t_work w;
        w.st  = st;
        w.bun = '0;
        if (eod) begin
            if (w.st.has_bytes || w.st.cr_pend || (w.st.held_cnt != 2'd0)) begin
                w = f_emit(w, 8'd0, ROLE_NONE, KIND_CMD, EV_NO_CRLF);
            end else begin
                w = f_emit(w, 8'd0, ROLE_NONE, KIND_CMD, EV_NO_DATA);
            end
            w.st = f_clear(w.st);
        end else if (w.st.cr_pend && (b == CH_LF)) begin
            w.st.cr_pend = 1'b0;
            if (!w.st.has_bytes && (w.st.held_cnt == 2'd0)) begin
                w = f_emit(w, 8'd0, ROLE_NONE, KIND_CMD, EV_EMPTY);
            end else begin
                if ((w.st.phase != PH_BODY) && (w.st.held_cnt != 2'd0)) begin
                    w = f_release(w);
                end
                w = f_emit(w, 8'd0, ROLE_NONE, w.st.kind, EV_LINE);
            end
            w.st = f_clear(w.st);
        end else begin
            if (w.st.cr_pend) begin
                w.st.cr_pend = 1'b0;
                w = f_data(w, CH_CR);
            end
            if (b == CH_CR) begin
                w.st.cr_pend = 1'b1;
            end else begin
                w = f_data(w, b);
            end
        end
        return w;
    endfunction

endpackage
`default_nettype wire

### src/plc_front.sv
// Front end: takes stream bytes, tracks line state and builds the result bundle per request.
`default_nettype none
module plc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [7:0]        i_in_byte,
    input  wire logic              i_end_of_data,
    input  wire logic              i_full,
    output plc_pkg::t_bundle       o_bundle,
    output logic                   o_push
);

    plc_pkg::t_line r_st;
    plc_pkg::t_line n_st;
    plc_pkg::t_work step;
    logic           acc;

    assign acc = i_valid && !i_full;

    always_comb begin
        step = plc_pkg::f_step(r_st, i_in_byte, i_end_of_data);
    end

    // next line state
    always_comb begin
        n_st = acc ? step.st : r_st;
    end

    // bundle to the queue; a request that only holds prefix bytes pushes nothing
    always_comb begin
        o_bundle = step.bun;
        o_push   = acc && (step.bun.cnt != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        r_st.held <= n_st.held;
        if (!i_rst_n) begin
            r_st.held_cnt   <= 2'd0;
            r_st.phase      <= plc_pkg::PH_START;
            r_st.kind       <= plc_pkg::KIND_CMD;
            r_st.space_seen <= 1'b0;
            r_st.drop_sp    <= 1'b0;
            r_st.cr_pend    <= 1'b0;
            r_st.has_bytes  <= 1'b0;
        end else begin
            r_st.held_cnt   <= n_st.held_cnt;
            r_st.phase      <= n_st.phase;
            r_st.kind       <= n_st.kind;
            r_st.space_seen <= n_st.space_seen;
            r_st.drop_sp    <= n_st.drop_sp;
            r_st.cr_pend    <= n_st.cr_pend;
            r_st.has_bytes  <= n_st.has_bytes;
        end
    end

`ifndef ASSERT_OFF
    a_held_in_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.held_cnt != 2'd0) |->
            (r_st.phase != plc_pkg::PH_BODY) && (r_st.phase != plc_pkg::PH_START))
        else $error("held prefix bytes outside a prefix phase");
    a_drop_on_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.drop_sp |-> (r_st.kind != plc_pkg::KIND_CMD))
        else $error("space drop armed on a command line");
`endif

endmodule
`default_nettype wire

### src/plc_queue.sv
// Bundle queue between the front end and the result serialiser.
`default_nettype none
module plc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire plc_pkg::t_bundle  i_data,
    input  wire logic              i_pop,
    output plc_pkg::t_bundle       o_data,
    output logic                   o_full,
    output logic                   o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    plc_pkg::t_bundle r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    n_wr;
    logic [AW-1:0]    n_rd;
    logic [CW-1:0]    n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : AW'(r_wr + 1'b1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : AW'(r_rd + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_cnt = CW'(r_cnt + 1'b1);
        end else if (do_pop && !do_push) begin
            n_cnt = CW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

### src/plc_back.sv
// Back end: walks the head bundle one result per cycle, while i_stall is low, into the output register.
`default_nettype none
module plc_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire plc_pkg::t_bundle  i_data,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [7:0]             o_out_byte,
    output logic [1:0]             o_byte_role,
    output logic [1:0]             o_line_kind,
    output logic [2:0]             o_event_res,
    output logic                   o_last
);

    logic              r_valid;
    logic              n_valid;
    logic [2:0]        r_idx;
    logic [2:0]        n_idx;
    plc_pkg::t_res     r_res;
    plc_pkg::t_res     n_res;
    logic              r_last;
    logic              n_last;
    logic              load;
    logic              fin;

    assign load = !r_valid || !i_stall;
    assign fin  = (r_idx == 3'(i_data.cnt - 3'd1));

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        n_res   = r_res;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                n_res  = i_data.res[r_idx];
                n_last = fin;
                if (fin) begin
                    o_pop = 1'b1;
                    n_idx = 3'd0;
                end else begin
                    n_idx = 3'(r_idx + 3'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_last <= n_last;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_res.data;
    assign o_byte_role = r_res.role;
    assign o_line_kind = r_res.kind;
    assign o_event_res = r_res.ev;
    assign o_last      = r_last;

`ifndef ASSERT_OFF
    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_idx < i_data.cnt))
        else $error("result index outside head bundle");
    a_bundle_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> o_valid)
        else $error("gap inside a result burst");
`endif

endmodule
`default_nettype wire

### src/pop3_line_classifier.sv
// Top level of the POP3 line classifier: front end, bundle queue and result serialiser.
// Usage:
//  - Input channel (i_valid / o_stall): one stream byte or an end-of-data mark per
//    request, taken at an edge with i_valid high and o_stall low. One request per
//    cycle is accepted while the queue has room.
//  - Output channel (o_valid / i_stall): one result per transfer, o_last on the final
//    result caused by an input. A request may cause zero to five results; one that
//    only holds prefix bytes or a CR causes none.
//  - Result path: the front end writes a request's bundle into the queue at the edge
//    that accepts it; a later edge loads the first result into the output register,
//    which drives o_valid.
//  - Throughput: one request per cycle in while the queue has room, one result per
//    cycle out while i_stall is low; a request's results hold the output in turn. The
//    queue of QUEUE_DEPTH bundles absorbs bursts; o_stall rises only once it is full.
//  - Receiver stall: the output register holds its result, the queue fills, then
//    o_stall goes high; no result is lost or repeated.
//  - Reset (synchronous, active low): line state returns to line start, queue and
//    output register empty. Held prefix bytes need no reset.
`default_nettype none
module pop3_line_classifier #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_data,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_byte_role,
    output logic [1:0]      o_line_kind,
    output logic [2:0]      o_event_res,
    output logic            o_last
);

    plc_pkg::t_bundle push_bun;
    plc_pkg::t_bundle head_bun;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    // input is held off only while the queue is full
    assign o_stall = full;

    plc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_in_byte     (i_in_byte),
        .i_end_of_data (i_end_of_data),
        .i_full        (full),
        .o_bundle      (push_bun),
        .o_push        (push)
    );

    plc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_bun),
        .i_pop   (pop),
        .o_data  (head_bun),
        .o_full  (full),
        .o_empty (empty)
    );

    plc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (head_bun),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_byte_role (o_byte_role),
        .o_line_kind (o_line_kind),
        .o_event_res (o_event_res),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

### bench/pop3_line_classifier_checker.sv
// Result checker for the POP3 line classifier: predicts each request's results and compares.
module pop3_line_classifier_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_stall,
    input  logic [7:0] i_req_byte,
    input  logic       i_req_eod,
    input  logic       i_res_valid,
    input  logic       i_res_stall,
    input  logic [7:0] i_res_byte,
    input  logic [1:0] i_res_role,
    input  logic [1:0] i_res_kind,
    input  logic [2:0] i_res_event,
    input  logic       i_res_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results,
    output int         o_lines
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] role;
        logic [1:0] kind;
        logic [2:0] ev;
        logic       last;
    } t_line_result;

    // Line state as the classifier should hold it.
    logic [7:0]       pfx_hold [3];
    int               pfx_len;
    plc_pkg::t_phase  phase;
    logic [1:0]       kind_now;
    logic             past_name;
    logic             drop_space;
    logic             cr_waiting;
    logic             line_started;

    t_line_result step_res [6];
    int           step_n;
    t_line_result awaited_results [$];

    int fails;
    int results_seen;
    int lines_seen;

    function automatic void clear_line_state();
        pfx_len      = 0;
        phase        = plc_pkg::PH_START;
        kind_now     = plc_pkg::KIND_CMD;
        past_name    = 1'b0;
        drop_space   = 1'b0;
        cr_waiting   = 1'b0;
        line_started = 1'b0;
    endfunction

    function automatic void note_result(logic [7:0] b, logic [1:0] role, logic [1:0] kind,
                                        logic [2:0] ev);
        t_line_result r;
        if (step_n < 6) begin
            r.data = b;
            r.role = role;
            r.kind = kind;
            r.ev   = ev;
            r.last = 1'b0;
            step_res[step_n] = r;
            step_n++;
        end
    endfunction

    // Payload byte once the prefix question is settled.
    function automatic void classify_payload(logic [7:0] b);
        if (drop_space) begin
            drop_space = 1'b0;
            if (b == plc_pkg::CH_SPACE) begin
                return;
            end
        end
        if (kind_now != plc_pkg::KIND_CMD) begin
            note_result(b, plc_pkg::ROLE_TEXT, kind_now, plc_pkg::EV_BYTE);
        end else if (!past_name) begin
            if (b == plc_pkg::CH_SPACE) begin
                past_name = 1'b1;
            end else begin
                note_result(b, plc_pkg::ROLE_NAME, plc_pkg::KIND_CMD, plc_pkg::EV_BYTE);
            end
        end else begin
            note_result(b, plc_pkg::ROLE_ARG, plc_pkg::KIND_CMD, plc_pkg::EV_BYTE);
        end
    endfunction

    function automatic void flush_prefix();
        int n;
        n        = pfx_len;
        phase    = plc_pkg::PH_BODY;
        kind_now = plc_pkg::KIND_CMD;
        pfx_len  = 0;
        for (int i = 0; i < n && i < 3; i++) begin
            classify_payload(pfx_hold[i]);
        end
    endfunction

    function automatic void keep_prefix(logic [7:0] b, plc_pkg::t_phase next_phase);
        if (pfx_len < 3) begin
            pfx_hold[pfx_len] = b;
        end
        pfx_len++;
        phase = next_phase;
    endfunction

    function automatic void prefix_matched(logic [1:0] kind);
        pfx_len    = 0;
        phase      = plc_pkg::PH_BODY;
        kind_now   = kind;
        drop_space = 1'b1;
    endfunction

    function automatic void take_byte(logic [7:0] b);
        line_started = 1'b1;
        case (phase)
            plc_pkg::PH_START: begin
                if (b == plc_pkg::CH_PLUS) begin
                    keep_prefix(b, plc_pkg::PH_PLUS);
                    return;
                end
                if (b == plc_pkg::CH_MINUS) begin
                    keep_prefix(b, plc_pkg::PH_MINUS);
                    return;
                end
                phase    = plc_pkg::PH_BODY;
                kind_now = plc_pkg::KIND_CMD;
            end
            plc_pkg::PH_PLUS: begin
                if (b == plc_pkg::CH_O) begin
                    keep_prefix(b, plc_pkg::PH_PLUS_O);
                    return;
                end
                flush_prefix();
            end
            plc_pkg::PH_PLUS_O: begin
                if (b == plc_pkg::CH_K) begin
                    prefix_matched(plc_pkg::KIND_POS);
                    return;
                end
                flush_prefix();
            end
            plc_pkg::PH_MINUS: begin
                if (b == plc_pkg::CH_E) begin
                    keep_prefix(b, plc_pkg::PH_MINUS_E);
                    return;
                end
                flush_prefix();
            end
            plc_pkg::PH_MINUS_E: begin
                if (b == plc_pkg::CH_R) begin
                    keep_prefix(b, plc_pkg::PH_MINUS_ER);
                    return;
                end
                flush_prefix();
            end
            plc_pkg::PH_MINUS_ER: begin
                if (b == plc_pkg::CH_R) begin
                    prefix_matched(plc_pkg::KIND_NEG);
                    return;
                end
                flush_prefix();
            end
            default: begin
            end
        endcase
        classify_payload(b);
    endfunction

    function automatic void predict_line_results(logic [7:0] b, logic eod);
        t_line_result r;
        step_n = 0;
        if (eod) begin
            if (line_started || cr_waiting || pfx_len != 0) begin
                note_result(8'd0, plc_pkg::ROLE_NONE, plc_pkg::KIND_CMD, plc_pkg::EV_NO_CRLF);
            end else begin
                note_result(8'd0, plc_pkg::ROLE_NONE, plc_pkg::KIND_CMD, plc_pkg::EV_NO_DATA);
            end
            clear_line_state();
        end else if (cr_waiting && b == plc_pkg::CH_LF) begin
            cr_waiting = 1'b0;
            if (!line_started && pfx_len == 0) begin
                note_result(8'd0, plc_pkg::ROLE_NONE, plc_pkg::KIND_CMD, plc_pkg::EV_EMPTY);
            end else begin
                if (phase != plc_pkg::PH_BODY && pfx_len != 0) begin
                    flush_prefix();
                end
                note_result(8'd0, plc_pkg::ROLE_NONE, kind_now, plc_pkg::EV_LINE);
            end
            clear_line_state();
        end else begin
            if (cr_waiting) begin
                cr_waiting = 1'b0;
                take_byte(plc_pkg::CH_CR);
            end
            if (b == plc_pkg::CH_CR) begin
                cr_waiting = 1'b1;
            end else begin
                take_byte(b);
            end
        end
        for (int i = 0; i < step_n; i++) begin
            r      = step_res[i];
            r.last = (i == step_n - 1);
            awaited_results.push_back(r);
        end
    endfunction

    function automatic void compare_field(string what, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_line_result want;
        if (!i_rst_n) begin
            clear_line_state();
            awaited_results.delete();
            fails        = 0;
            results_seen = 0;
            lines_seen   = 0;
        end else begin
            if (i_req_valid && !i_req_stall) begin
                predict_line_results(i_req_byte, i_req_eod);
            end
            if (i_res_valid && !i_res_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual byte 0x%0h event %0d",
                             $time, i_res_byte, i_res_event);
                    fails++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("out_byte", want.data, i_res_byte);
                    compare_field("byte_role", want.role, i_res_role);
                    compare_field("line_kind", want.kind, i_res_kind);
                    compare_field("event_res", want.ev, i_res_event);
                    compare_field("last", want.last, i_res_last);
                    results_seen++;
                    if (want.ev == plc_pkg::EV_LINE) begin
                        lines_seen++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited_results.size();
        o_results    <= results_seen;
        o_lines      <= lines_seen;
    end

endmodule

### bench/pop3_line_classifier_test.sv
// Top of the POP3 line classifier bench: clock, reset, request and result traffic, verdict.
module pop3_line_classifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS    = 145;
    localparam int HOLD_OFF_CYCLES = 80;   // long enough to fill the bundle queue
    localparam int DRAIN_CYCLES    = 20;   // leave a margin after the results drain

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_in_byte;
    logic       i_end_of_data;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic [1:0] o_byte_role;
    logic [1:0] o_line_kind;
    logic [2:0] o_event_res;
    logic       o_last;

    int fail_count;
    int pending;
    int results_checked;
    int lines_checked;

    // Request side bookkeeping.
    int sent_count  = 0;
    int eod_count   = 0;
    int tx_calm     = 0;   // requests left in a stretch without sender gaps
    bit hold_off_req = 1'b0;

    pop3_line_classifier i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .i_end_of_data (i_end_of_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_role   (o_byte_role),
        .o_line_kind   (o_line_kind),
        .o_event_res   (o_event_res),
        .o_last        (o_last)
    );

    pop3_line_classifier_checker results_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_req_byte   (i_in_byte),
        .i_req_eod    (i_end_of_data),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_res_byte   (o_out_byte),
        .i_res_role   (o_byte_role),
        .i_res_kind   (o_line_kind),
        .i_res_event  (o_event_res),
        .i_res_last   (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results_checked),
        .o_lines      (lines_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run (about 200 requests, five results each,
    // every result behind a long receiver stall).
    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    // One request: hold it until taken, then maybe leave a gap. Valid stays high straight
    // into the next request when no gap is chosen, so it is never dropped and re-raised
    // within one step.
    task automatic send_request(input logic [7:0] b, input logic eod);
        int gap;
        i_valid       <= 1'b1;
        i_in_byte     <= b;
        i_end_of_data <= eod;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
        if (eod) begin
            eod_count++;
        end
        if (tx_calm > 0) begin
            tx_calm--;
        end else if ($urandom_range(0, 19) == 0) begin
            tx_calm = $urandom_range(10, 40);
        end else if ($urandom_range(0, 2) == 0) begin
            // mostly short gaps, now and then a long one
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_request(s[i], 1'b0);
        end
    endtask

    task automatic send_crlf();
        send_request(plc_pkg::CH_CR, 1'b0);
        send_request(plc_pkg::CH_LF, 1'b0);
    endtask

    task automatic send_eod();
        // the byte lane is ignored here, so it carries random noise
        send_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Mostly printable text, with spaces, stray CRs and the odd arbitrary byte.
    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 11);
        if (r == 0) begin
            return 8'($urandom_range(0, 255));
        end
        if (r == 1 || r == 2) begin
            return plc_pkg::CH_SPACE;
        end
        if (r == 3) begin
            return plc_pkg::CH_CR;
        end
        return 8'($urandom_range(8'h21, 8'h7e));
    endfunction

    task automatic send_body(input int n);
        for (int i = 0; i < n; i++) begin
            send_request(pick_text_byte(), 1'b0);
        end
    endtask

    // One random line: mostly well-formed responses and commands, some broken prefixes,
    // empty lines and raw noise; usually closed by CR LF, sometimes cut by end of data.
    task automatic send_random_line();
        int sel;
        int tail;
        sel = $urandom_range(0, 99);
        if (sel < 28) begin
            send_text("+OK");
            if ($urandom_range(0, 3) != 0) begin
                send_request(plc_pkg::CH_SPACE, 1'b0);
            end
            send_body($urandom_range(0, 5));
        end else if (sel < 48) begin
            send_text("-ERR");
            if ($urandom_range(0, 3) != 0) begin
                send_request(plc_pkg::CH_SPACE, 1'b0);
            end
            send_body($urandom_range(0, 5));
        end else if (sel < 74) begin
            // command name, then optionally a space and an argument
            for (int i = $urandom_range(1, 4); i > 0; i--) begin
                send_request(8'($urandom_range(8'h41, 8'h5a)), 1'b0);
            end
            if ($urandom_range(0, 2) != 0) begin
                send_request(plc_pkg::CH_SPACE, 1'b0);
                send_body($urandom_range(0, 4));
            end
        end else if (sel < 86) begin
            // a prefix that starts well and then goes astray (or stops short)
            case ($urandom_range(0, 4))
                0:       send_text("+");
                1:       send_text("+O");
                2:       send_text("-");
                3:       send_text("-E");
                default: send_text("-ER");
            endcase
            send_body($urandom_range(0, 3));
        end else if (sel < 93) begin
            // empty line: the terminator below is all there is
        end else begin
            for (int i = $urandom_range(1, 6); i > 0; i--) begin
                send_request(8'($urandom_range(0, 255)), 1'b0);
            end
        end

        tail = $urandom_range(0, 19);
        if (tail < 16) begin
            send_crlf();
        end else if (tail < 18) begin
            send_eod();
        end else if (tail == 18) begin
            // CR left pending when the data runs out
            send_request(plc_pkg::CH_CR, 1'b0);
            send_eod();
        end
        // otherwise the line runs on into the next one

        if ($urandom_range(0, 15) == 0) begin
            send_eod();
        end
    endtask

    // Result side: random stalls, stretches without any, and one long hold-off on request.
    initial begin : result_sink
        int gap;
        int calm_left;
        calm_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 29) == 0) begin
                calm_left = $urandom_range(20, 60);
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : request_source
        int directed_n;
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_in_byte     <= 8'd0;
        i_end_of_data <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        // End of data with nothing received: no-data event.
        send_eod();
        // Bare CR LF: empty line.
        send_crlf();
        // Positive response; the space after the prefix is dropped, top byte value as text.
        send_text("+OK ");
        send_request(8'hff, 1'b0);
        send_crlf();
        // Prefix cut short by CR LF: held bytes come out as command name, then line done.
        send_text("-ER");
        send_crlf();
        // Negative response with no text at all.
        send_text("-ERR");
        send_crlf();
        // Broken prefix releases the held byte; a CR not followed by LF becomes payload;
        // zero byte; then end of data on a partial line.
        send_text("+x");
        send_request(plc_pkg::CH_CR, 1'b0);
        send_request(8'h00, 1'b0);
        send_eod();
        directed_n = sent_count;

        // Random part.
        while (sent_count < directed_n + RANDOM_ITEMS) begin
            if (!hold_done && sent_count > directed_n + 60) begin
                // receiver holds off while requests keep coming, so the queue fills
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && sent_count > directed_n + 110) begin
                // sender waits until every awaited result has come out
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
                pause_done = 1'b1;
            end
            send_random_line();
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d requests (%0d end-of-data), %0d results checked, %0d lines closed.",
                 sent_count, eod_count, results_checked, lines_checked);
        $display("Covered responses, commands, broken prefixes, stray CRs, empty and cut lines.");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
